// ===== hdl/tmq_pkg.sv =====
// Shared constants, codes and types of the tile map quad generator.
package tmq_pkg;

    localparam int MAX_MAP_COLS = 128;
    localparam int MAX_MAP_ROWS = 128;
    localparam int TILE_BITS    = 16;
    localparam int COL_BITS     = $clog2(MAX_MAP_COLS);
    localparam int ROW_BITS     = $clog2(MAX_MAP_ROWS);
    localparam int ADDR_BITS    = ROW_BITS + COL_BITS;
    localparam int DEPTH        = MAX_MAP_ROWS * MAX_MAP_COLS;

    localparam int DVD_BITS = 17;
    localparam int DVS_BITS = 9;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_AREA  = 2'd1,
        ACT_STEP  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_VERTEX = 2'd1,
        KIND_SKIP   = 2'd2,
        KIND_EMPTY  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CFG_ATLAS_COLUMNS = 3'd0,
        CFG_MAP_WIDTH     = 3'd1,
        CFG_MAP_HEIGHT    = 3'd2,
        CFG_TILE_WIDTH    = 3'd3,
        CFG_TILE_HEIGHT   = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AREA_START,
        ST_AREA_WAIT,
        ST_AREA_FIN,
        ST_STEP_EVAL,
        ST_SKIP,
        ST_MOD_WAIT,
        ST_MUL,
        ST_VERT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [DVD_BITS-1:0] dividend;
        logic [DVS_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic                busy;
        logic [DVD_BITS-1:0] quotient;
        logic [DVS_BITS-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
    } range_t;

endpackage

// ===== hdl/tmq_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module tmq_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  tmq_pkg::div_req_t req,
    output tmq_pkg::div_rsp_t rsp
);
    import tmq_pkg::*;

    logic [DVS_BITS-1:0] rem_reg, rem_next;
    logic [DVD_BITS-1:0] quo_reg, quo_next;
    logic [DVS_BITS-1:0] dvs_reg, dvs_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DVS_BITS:0]   trial;

    always_comb begin
        trial     = {rem_reg, quo_reg[DVD_BITS-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = 5'(DVD_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DVS_BITS'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DVD_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_BITS-1:0];
                quo_next = {quo_reg[DVD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hdl/tmq_tile_ram.sv =====
// Tile map memory: one write port and one registered read port.
module tmq_tile_ram (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [tmq_pkg::ADDR_BITS-1:0]          waddr,
    input  logic [tmq_pkg::TILE_BITS-1:0]          wdata,
    input  logic                                   re,
    input  logic [tmq_pkg::ADDR_BITS-1:0]          raddr,
    output logic [tmq_pkg::TILE_BITS-1:0]          rdata
);
    import tmq_pkg::*;

    logic [TILE_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/tile_map_quad_generator_core.sv =====
// Tile map quad generator: tile store, render range walker and vertex emitter.
// A write request is acknowledged through the output register; a set-area request makes
// four passes through the bit-serial divider. A step request reads the tile memory, then
// for a filled cell runs the divider for the atlas column, forms the products and emits
// four vertices, one per cycle while the receiver is ready. One request is worked on at a
// time. Reset clears the control and walk state and configuration, not the tile memory.
module tile_map_quad_generator_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_action,
    input  logic [6:0]                         s_cell_row,
    input  logic [6:0]                         s_cell_col,
    input  logic signed [15:0]                 s_tile_value,
    input  logic signed [15:0]                 s_area_x,
    input  logic signed [15:0]                 s_area_y,
    input  logic [15:0]                        s_area_w,
    input  logic [15:0]                        s_area_h,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_kind,
    output logic [15:0]                        m_pos_x,
    output logic [15:0]                        m_pos_y,
    output logic [15:0]                        m_tex_x,
    output logic [8:0]                         m_tex_y,
    output logic [1:0]                         m_corner,
    output logic                               m_last,
    output logic                               m_area_done,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_index,
    input  logic [8:0]                         cfg_data
);
    import tmq_pkg::*;

    // Configuration registers.
    logic [7:0] atlas_reg, mapw_reg, maph_reg;
    logic [8:0] tilew_reg, tileh_reg;

    // Walk state.
    logic [7:0] start_col_reg, start_col_next;
    logic [7:0] end_col_reg, end_col_next;
    logic [7:0] end_row_reg, end_row_next;
    logic [7:0] cursor_row_reg, cursor_row_next;
    logic [7:0] cursor_col_reg, cursor_col_next;
    logic       walk_reg, walk_next;

    state_t state_reg, state_next;

    // Working registers of the current request.
    logic signed [15:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [17:0] sumx_reg, sumx_next, sumy_reg, sumy_next;
    logic [1:0]          idx_reg, idx_next;
    logic [DVD_BITS-1:0] q_reg [4];
    logic [DVD_BITS-1:0] q_next [4];
    logic [7:0]  cur_r_reg, cur_r_next, cur_c_reg, cur_c_next;
    logic        done_reg, done_next;
    logic [7:0]  mod_reg, mod_next;
    logic [15:0] x0_reg, x0_next, x1_reg, x1_next;
    logic [15:0] y0_reg, y0_next, y1_reg, y1_next;
    logic [15:0] t0_reg, t0_next, t1_reg, t1_next;
    logic [1:0]  corner_reg, corner_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_kind_reg, m_kind_next;
    logic [15:0] m_pos_x_reg, m_pos_x_next, m_pos_y_reg, m_pos_y_next;
    logic [15:0] m_tex_x_reg, m_tex_x_next;
    logic [8:0]  m_tex_y_reg, m_tex_y_next;
    logic [1:0]  m_corner_reg, m_corner_next;
    logic        m_last_reg, m_last_next, m_done_reg, m_done_next;

    logic       free, accept;
    logic [8:0] tw, th;
    logic [7:0] atlas_nz, lim_c, lim_r;
    range_t     rng_c, rng_r;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                 ram_we, ram_re;
    logic [TILE_BITS-1:0] ram_rdata;

    // A zero register acts as one; map sizes are limited to the store.
    assign tw       = (tilew_reg == 9'd0) ? 9'd1 : tilew_reg;
    assign th       = (tileh_reg == 9'd0) ? 9'd1 : tileh_reg;
    assign atlas_nz = (atlas_reg == 8'd0) ? 8'd1 : atlas_reg;
    assign lim_c    = (mapw_reg > 8'(MAX_MAP_COLS)) ? 8'(MAX_MAP_COLS) : mapw_reg;
    assign lim_r    = (maph_reg > 8'(MAX_MAP_ROWS)) ? 8'(MAX_MAP_ROWS) : maph_reg;

    // The output slot is free when empty or being taken in this cycle. A new
    // request is taken only when idle with a free slot, so single-result
    // requests can answer at once.
    assign free    = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE) && free;
    assign accept  = s_valid && s_ready;

    // Clamped tile range along one axis. A negative start is zero. A negative
    // end sum truncates toward zero, so the end is one only while its
    // magnitude stays below one tile.
    function automatic range_t axis_range(input logic pos_neg,
                                          input logic [DVD_BITS-1:0] qs,
                                          input logic signed [17:0] sum,
                                          input logic [DVD_BITS-1:0] qe,
                                          input logic [8:0] tile,
                                          input logic [7:0] lim);
        logic [17:0] mag;
        logic [17:0] e;
        logic [17:0] s;
        range_t      r;
        mag = 18'(-sum);
        if (sum[17]) begin
            e = (mag < {9'd0, tile}) ? 18'd1 : 18'd0;
        end else begin
            e = {1'b0, qe} + 18'd1;
        end
        s = pos_neg ? 18'd0 : {1'b0, qs};
        if (e > {10'd0, lim}) begin
            e = {10'd0, lim};
        end
        if (s > e) begin
            s = e;
        end
        r.lo = s[7:0];
        r.hi = e[7:0];
        return r;
    endfunction

    assign rng_c = axis_range(ax_reg[15], q_reg[0], sumx_reg, q_reg[1], tw, lim_c);
    assign rng_r = axis_range(ay_reg[15], q_reg[2], sumy_reg, q_reg[3], th, lim_r);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_AREA) begin
                        state_next = ST_AREA_START;
                    end else if (s_action == ACT_STEP && walk_reg &&
                                 !cursor_row_reg[7] && !cursor_col_reg[7]) begin
                        state_next = ST_STEP_EVAL;
                    end
                end
            end
            ST_AREA_START: state_next = ST_AREA_WAIT;
            ST_AREA_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (idx_reg == 2'd3) ? ST_AREA_FIN : ST_AREA_START;
                end
            end
            ST_AREA_FIN: begin
                if (free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEP_EVAL: state_next = ram_rdata[TILE_BITS-1] ? ST_SKIP : ST_MOD_WAIT;
            ST_SKIP: begin
                if (free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOD_WAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_VERT;
            ST_VERT: begin
                if (free && corner_reg == 2'd3) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        start_col_next  = start_col_reg;
        end_col_next    = end_col_reg;
        end_row_next    = end_row_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        walk_next       = walk_reg;
        ax_next   = ax_reg;
        ay_next   = ay_reg;
        sumx_next = sumx_reg;
        sumy_next = sumy_reg;
        idx_next  = idx_reg;
        q_next    = q_reg;
        cur_r_next  = cur_r_reg;
        cur_c_next  = cur_c_reg;
        done_next   = done_reg;
        mod_next    = mod_reg;
        x0_next = x0_reg;
        x1_next = x1_reg;
        y0_next = y0_reg;
        y1_next = y1_reg;
        t0_next = t0_reg;
        t1_next = t1_reg;
        corner_next = corner_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_pos_x_next  = m_pos_x_reg;
        m_pos_y_next  = m_pos_y_reg;
        m_tex_x_next  = m_tex_x_reg;
        m_tex_y_next  = m_tex_y_reg;
        m_corner_next = m_corner_reg;
        m_last_next   = m_last_reg;
        m_done_next   = m_done_reg;

        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        ram_we = 1'b0;
        ram_re = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_action)
                        ACT_WRITE: begin
                            ram_we        = 1'b1;
                            m_valid_next  = 1'b1;
                            m_kind_next   = KIND_ACK;
                            m_pos_x_next  = '0;
                            m_pos_y_next  = '0;
                            m_tex_x_next  = '0;
                            m_tex_y_next  = '0;
                            m_corner_next = '0;
                            m_last_next   = 1'b1;
                            m_done_next   = 1'b0;
                        end
                        ACT_AREA: begin
                            ax_next   = s_area_x;
                            ay_next   = s_area_y;
                            sumx_next = 18'(s_area_x) + 18'(signed'({1'b0, s_area_w}));
                            sumy_next = 18'(s_area_y) + 18'(signed'({1'b0, s_area_h}));
                            idx_next  = 2'd0;
                        end
                        ACT_STEP: begin
                            if (walk_reg && !cursor_row_reg[7] && !cursor_col_reg[7]) begin
                                ram_re     = 1'b1;
                                cur_r_next = cursor_row_reg;
                                cur_c_next = cursor_col_reg;
                            end else begin
                                walk_next     = 1'b0;
                                m_valid_next  = 1'b1;
                                m_kind_next   = KIND_EMPTY;
                                m_pos_x_next  = '0;
                                m_pos_y_next  = '0;
                                m_tex_x_next  = '0;
                                m_tex_y_next  = '0;
                                m_corner_next = '0;
                                m_last_next   = 1'b1;
                                m_done_next   = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_AREA_START: begin
                // Passes: start column, end column, start row, end row.
                div_req.start   = 1'b1;
                div_req.divisor = idx_reg[1] ? th : tw;
                case (idx_reg)
                    2'd0: div_req.dividend = ax_reg[15] ? '0 : {2'b0, ax_reg[14:0]};
                    2'd1: div_req.dividend = sumx_reg[17] ? '0 : sumx_reg[16:0];
                    2'd2: div_req.dividend = ay_reg[15] ? '0 : {2'b0, ay_reg[14:0]};
                    default: div_req.dividend = sumy_reg[17] ? '0 : sumy_reg[16:0];
                endcase
            end
            ST_AREA_WAIT: begin
                if (div_rsp.done) begin
                    q_next[idx_reg] = div_rsp.quotient;
                    idx_next        = idx_reg + 2'd1;
                end
            end
            ST_AREA_FIN: begin
                if (free) begin
                    start_col_next  = rng_c.lo;
                    end_col_next    = rng_c.hi;
                    end_row_next    = rng_r.hi;
                    cursor_row_next = rng_r.lo;
                    cursor_col_next = rng_c.lo;
                    walk_next       = (rng_c.lo < rng_c.hi) && (rng_r.lo < rng_r.hi);
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_ACK;
                    m_pos_x_next  = '0;
                    m_pos_y_next  = '0;
                    m_tex_x_next  = '0;
                    m_tex_y_next  = '0;
                    m_corner_next = '0;
                    m_last_next   = 1'b1;
                    m_done_next   = 1'b0;
                end
            end
            ST_STEP_EVAL: begin
                // Advance the cursor in row-major order over the range.
                done_next = 1'b0;
                if ({1'b0, cur_c_reg} + 9'd1 < {1'b0, end_col_reg}) begin
                    cursor_col_next = cur_c_reg + 8'd1;
                end else begin
                    cursor_col_next = start_col_reg;
                    cursor_row_next = cur_r_reg + 8'd1;
                    if ({1'b0, cur_r_reg} + 9'd1 >= {1'b0, end_row_reg}) begin
                        walk_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                if (!ram_rdata[TILE_BITS-1]) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_BITS'(ram_rdata);
                    div_req.divisor  = {1'b0, atlas_nz};
                end
            end
            ST_SKIP: begin
                if (free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_SKIP;
                    m_pos_x_next  = '0;
                    m_pos_y_next  = '0;
                    m_tex_x_next  = '0;
                    m_tex_y_next  = '0;
                    m_corner_next = '0;
                    m_last_next   = 1'b1;
                    m_done_next   = done_reg;
                end
            end
            ST_MOD_WAIT: begin
                if (div_rsp.done) begin
                    mod_next = div_rsp.remainder[7:0];
                end
            end
            ST_MUL: begin
                // Products are formed at 16 bits, so positions and texture x wrap there.
                x0_next = {8'd0, cur_c_reg} * {7'd0, tw};
                x1_next = ({8'd0, cur_c_reg} + 16'd1) * {7'd0, tw};
                y0_next = {8'd0, cur_r_reg} * {7'd0, th};
                y1_next = ({8'd0, cur_r_reg} + 16'd1) * {7'd0, th};
                t0_next = {8'd0, mod_reg} * {7'd0, tw};
                t1_next = ({8'd0, mod_reg} + 16'd1) * {7'd0, tw};
                corner_next = 2'd0;
            end
            ST_VERT: begin
                if (free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_VERTEX;
                    m_pos_x_next  = (corner_reg inside {2'd1, 2'd2}) ? x1_reg : x0_reg;
                    m_pos_y_next  = corner_reg[1] ? y1_reg : y0_reg;
                    m_tex_x_next  = (corner_reg inside {2'd1, 2'd2}) ? t1_reg : t0_reg;
                    m_tex_y_next  = corner_reg[1] ? th : 9'd0;
                    m_corner_next = corner_reg;
                    m_last_next   = (corner_reg == 2'd3);
                    m_done_next   = done_reg;
                    corner_next   = corner_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            atlas_reg      <= 8'd1;
            mapw_reg       <= 8'd0;
            maph_reg       <= 8'd0;
            tilew_reg      <= 9'd16;
            tileh_reg      <= 9'd16;
            start_col_reg  <= '0;
            end_col_reg    <= '0;
            end_row_reg    <= '0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            walk_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            start_col_reg  <= start_col_next;
            end_col_reg    <= end_col_next;
            end_row_reg    <= end_row_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            walk_reg       <= walk_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ATLAS_COLUMNS: atlas_reg <= cfg_data[7:0];
                    CFG_MAP_WIDTH:     mapw_reg  <= cfg_data[7:0];
                    CFG_MAP_HEIGHT:    maph_reg  <= cfg_data[7:0];
                    CFG_TILE_WIDTH:    tilew_reg <= cfg_data;
                    CFG_TILE_HEIGHT:   tileh_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        sumx_reg   <= sumx_next;
        sumy_reg   <= sumy_next;
        idx_reg    <= idx_next;
        q_reg      <= q_next;
        cur_r_reg  <= cur_r_next;
        cur_c_reg  <= cur_c_next;
        done_reg   <= done_next;
        mod_reg    <= mod_next;
        x0_reg     <= x0_next;
        x1_reg     <= x1_next;
        y0_reg     <= y0_next;
        y1_reg     <= y1_next;
        t0_reg     <= t0_next;
        t1_reg     <= t1_next;
        corner_reg <= corner_next;
        m_kind_reg   <= m_kind_next;
        m_pos_x_reg  <= m_pos_x_next;
        m_pos_y_reg  <= m_pos_y_next;
        m_tex_x_reg  <= m_tex_x_next;
        m_tex_y_reg  <= m_tex_y_next;
        m_corner_reg <= m_corner_next;
        m_last_reg   <= m_last_next;
        m_done_reg   <= m_done_next;
    end

    tmq_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    tmq_tile_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr ({s_cell_row, s_cell_col}),
        .wdata (s_tile_value),
        .re    (ram_re),
        .raddr ({cursor_row_reg[ROW_BITS-1:0], cursor_col_reg[COL_BITS-1:0]}),
        .rdata (ram_rdata)
    );

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_pos_x     = m_pos_x_reg;
    assign m_pos_y     = m_pos_y_reg;
    assign m_tex_x     = m_tex_x_reg;
    assign m_tex_y     = m_tex_y_reg;
    assign m_corner    = m_corner_reg;
    assign m_last      = m_last_reg;
    assign m_area_done = m_done_reg;

    // A new request is only taken while no earlier result still waits.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid_reg || m_ready))
        else $error("request taken while a result is pending");

    // The divider only runs during the range and atlas column passes.
    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> (state_reg == ST_AREA_WAIT || state_reg == ST_MOD_WAIT))
        else $error("divider busy outside a divide state");

    // While the quad is emitted, any shown result is one of its vertices.
    a_vert_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VERT && m_valid_reg) |-> (m_kind_reg == KIND_VERTEX))
        else $error("non-vertex result during quad emission");

endmodule

// ===== tb/tmq_checker.sv =====
// Request/result checker for the tile map quad generator: predicts and compares results.
module tmq_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic [6:0]         s_cell_row,
    input  logic [6:0]         s_cell_col,
    input  logic signed [15:0] s_tile_value,
    input  logic signed [15:0] s_area_x,
    input  logic signed [15:0] s_area_y,
    input  logic [15:0]        s_area_w,
    input  logic [15:0]        s_area_h,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_kind,
    input  logic [15:0]        m_pos_x,
    input  logic [15:0]        m_pos_y,
    input  logic [15:0]        m_tex_x,
    input  logic [8:0]         m_tex_y,
    input  logic [1:0]         m_corner,
    input  logic               m_last,
    input  logic               m_area_done,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    output int                 fail_count,
    output int                 pending_count,
    output logic               walk_live,
    output logic [7:0]         walk_row,
    output logic [7:0]         walk_col
);
    import tmq_pkg::*;

    typedef struct {
        kind_t      kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] tex_x;
        logic [8:0]  tex_y;
        logic [1:0]  corner;
        logic        last;
        logic        done;
    } quad_result_t;

    quad_result_t expected_results[$];

    logic signed [15:0] tile_mem [DEPTH];
    logic [7:0] start_col, end_col, end_row, cur_row, cur_col;
    logic       live;
    logic [7:0] atlas_cols, map_w, map_h;
    logic [8:0] tile_w, tile_h;

    assign pending_count = expected_results.size();
    assign walk_live = live;
    assign walk_row  = cur_row;
    assign walk_col  = cur_col;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, want %0d", what, got, want);
        fail_count++;
    endtask

    function automatic void push_result(input kind_t k, input int px, input int py,
                                        input int tx, input int ty, input int cn,
                                        input bit last, input bit done);
        quad_result_t r;
        r.kind   = k;
        r.pos_x  = px[15:0];
        r.pos_y  = py[15:0];
        r.tex_x  = tx[15:0];
        r.tex_y  = ty[8:0];
        r.corner = cn[1:0];
        r.last   = last;
        r.done   = done;
        expected_results = {expected_results, r};
    endfunction

    // Tile span along one axis, clamped to zero and to the map limit.
    function automatic void tile_span(input int pos, input int size, input int tile,
                                      input int lim, output int s, output int e);
        s = pos / tile;
        e = (pos + size) / tile + 1;
        if (s < 0) s = 0;
        if (e < 0) e = 0;
        if (e > lim) e = lim;
        if (s > e) s = e;
    endfunction

    task automatic predict_request();
        int tw, th, ac, lim_c, lim_r, sc, ec, sr, er, r, c, m;
        logic signed [15:0] t;
        bit done;
        tw = (tile_w == 9'd0) ? 1 : int'(tile_w);
        th = (tile_h == 9'd0) ? 1 : int'(tile_h);
        ac = (atlas_cols == 8'd0) ? 1 : int'(atlas_cols);
        case (action_t'(s_action))
            ACT_WRITE: begin
                tile_mem[{s_cell_row, s_cell_col}] = s_tile_value;
                push_result(KIND_ACK, 0, 0, 0, 0, 0, 1, 0);
            end
            ACT_AREA: begin
                lim_c = (int'(map_w) < MAX_MAP_COLS) ? int'(map_w) : MAX_MAP_COLS;
                lim_r = (int'(map_h) < MAX_MAP_ROWS) ? int'(map_h) : MAX_MAP_ROWS;
                tile_span(int'(s_area_x), int'(s_area_w), tw, lim_c, sc, ec);
                tile_span(int'(s_area_y), int'(s_area_h), th, lim_r, sr, er);
                start_col = sc[7:0];
                end_col   = ec[7:0];
                end_row   = er[7:0];
                cur_row   = sr[7:0];
                cur_col   = sc[7:0];
                live      = (sc < ec) && (sr < er);
                push_result(KIND_ACK, 0, 0, 0, 0, 0, 1, 0);
            end
            ACT_STEP: begin
                if (!live || cur_row >= MAX_MAP_ROWS || cur_col >= MAX_MAP_COLS) begin
                    live = 1'b0;
                    push_result(KIND_EMPTY, 0, 0, 0, 0, 0, 1, 0);
                end else begin
                    r = int'(cur_row);
                    c = int'(cur_col);
                    t = tile_mem[r * MAX_MAP_COLS + c];
                    done = 1'b0;
                    if (c + 1 < int'(end_col)) begin
                        cur_col = 8'(c + 1);
                    end else begin
                        cur_col = start_col;
                        cur_row = 8'(r + 1);
                        if (r + 1 >= int'(end_row)) begin
                            live = 1'b0;
                            done = 1'b1;
                        end
                    end
                    if (t < 0) begin
                        push_result(KIND_SKIP, 0, 0, 0, 0, 0, 1, done);
                    end else begin
                        m = int'(t) % ac;
                        push_result(KIND_VERTEX, c * tw, r * th, m * tw, 0, 0, 0, done);
                        push_result(KIND_VERTEX, (c + 1) * tw, r * th, (m + 1) * tw, 0, 1,
                                    0, done);
                        push_result(KIND_VERTEX, (c + 1) * tw, (r + 1) * th, (m + 1) * tw,
                                    th, 2, 0, done);
                        push_result(KIND_VERTEX, c * tw, (r + 1) * th, m * tw, th, 3, 1,
                                    done);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        quad_result_t want;
        if (!aresetn) begin
            start_col  = '0;
            end_col    = '0;
            end_row    = '0;
            cur_row    = '0;
            cur_col    = '0;
            live       = 1'b0;
            atlas_cols = 8'd1;
            map_w      = '0;
            map_h      = '0;
            tile_w     = 9'd16;
            tile_h     = 9'd16;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected, kind", m_kind, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_kind != want.kind) report_mismatch("kind", m_kind, want.kind);
                    if (m_pos_x != want.pos_x) report_mismatch("pos_x", m_pos_x, want.pos_x);
                    if (m_pos_y != want.pos_y) report_mismatch("pos_y", m_pos_y, want.pos_y);
                    if (m_tex_x != want.tex_x) report_mismatch("tex_x", m_tex_x, want.tex_x);
                    if (m_tex_y != want.tex_y) report_mismatch("tex_y", m_tex_y, want.tex_y);
                    if (m_corner != want.corner)
                        report_mismatch("corner", m_corner, want.corner);
                    if (m_last != want.last) report_mismatch("last", m_last, want.last);
                    if (m_area_done != want.done)
                        report_mismatch("area_done", m_area_done, want.done);
                end
            end
            if (s_valid && s_ready) predict_request();
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_ATLAS_COLUMNS: atlas_cols = cfg_data[7:0];
                    CFG_MAP_WIDTH:     map_w      = cfg_data[7:0];
                    CFG_MAP_HEIGHT:    map_h      = cfg_data[7:0];
                    CFG_TILE_WIDTH:    tile_w     = cfg_data;
                    CFG_TILE_HEIGHT:   tile_h     = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    initial fail_count = 0;

endmodule

// ===== tb/tb_tile_map_quad_generator_core.sv =====
// Testbench top for the tile map quad generator: stimulus, handshake pacing and verdict.
module tb_tile_map_quad_generator_core;
    import tmq_pkg::*;

    // Cycles with no accepted request or result before the run is called hung.
    // The longest legal quiet stretch is the receiver hold-off.
    localparam int HANG_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 150;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_action;
    logic [6:0]         s_cell_row;
    logic [6:0]         s_cell_col;
    logic signed [15:0] s_tile_value;
    logic signed [15:0] s_area_x;
    logic signed [15:0] s_area_y;
    logic [15:0]        s_area_w;
    logic [15:0]        s_area_h;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_kind;
    logic [15:0]        m_pos_x;
    logic [15:0]        m_pos_y;
    logic [15:0]        m_tex_x;
    logic [8:0]         m_tex_y;
    logic [1:0]         m_corner;
    logic               m_last;
    logic               m_area_done;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [8:0]         cfg_data;

    int         fail_count;
    int         pending_count;
    logic       walk_live;
    logic [7:0] walk_row;
    logic [7:0] walk_col;

    // Cells written so far; a step is never allowed to visit a cell not in here.
    bit   written_cells [DEPTH];
    // Shadow copies of the registers, used only to aim render areas at the map.
    int   cur_map_w, cur_map_h, cur_tile_w, cur_tile_h;
    bit   sender_calm;
    bit   hold_request;
    int   quiet_cycles;

    tile_map_quad_generator_core dut (.*);

    tmq_checker checker_i (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_action, .s_cell_row, .s_cell_col, .s_tile_value,
        .s_area_x, .s_area_y, .s_area_w, .s_area_h,
        .m_valid, .m_ready, .m_kind, .m_pos_x, .m_pos_y, .m_tex_x, .m_tex_y,
        .m_corner, .m_last, .m_area_done,
        .cfg_we, .cfg_index, .cfg_data,
        .fail_count, .pending_count, .walk_live, .walk_row, .walk_col
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: any accepted request or result restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Result side. Each result gets its own random stall, with calm stretches where
    // the receiver is always ready. When the stimulus asks for a hold-off, ready stays
    // low for a long stretch so the block backs up and stops taking requests.
    initial begin
        bit calm;
        int stall;
        calm = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                if ($urandom_range(0, 15) == 0) calm = !calm;
                stall = calm ? 0 : $urandom_range(0, 16);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
                while (!m_valid) @(posedge aclk);
            end
        end
    end

    // Offers one request and returns at the edge where it is accepted. Valid is only
    // lowered when there is a gap, so back-to-back requests keep it high.
    task automatic send_request(input action_t act, input logic [6:0] row,
                                input logic [6:0] col, input logic [15:0] value,
                                input logic [15:0] ax, input logic [15:0] ay,
                                input logic [15:0] aw, input logic [15:0] ah);
        int gap;
        if ($urandom_range(0, 19) == 0) sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_cell_row   <= row;
        s_cell_col   <= col;
        s_tile_value <= value;
        s_area_x     <= ax;
        s_area_y     <= ay;
        s_area_w     <= aw;
        s_area_h     <= ah;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_cell(input logic [6:0] row, input logic [6:0] col,
                              input logic [15:0] value);
        send_request(ACT_WRITE, row, col, value, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
        written_cells[{row, col}] = 1'b1;
    endtask

    task automatic set_area(input logic [15:0] ax, input logic [15:0] ay,
                            input logic [15:0] aw, input logic [15:0] ah);
        send_request(ACT_AREA, 7'($urandom), 7'($urandom), 16'($urandom), ax, ay, aw, ah);
    endtask

    // A step request. Valid is dropped first so the checker settles the walk position,
    // and the cell the step will visit gets a random tile first if it has none yet.
    task automatic step_walk();
        s_valid <= 1'b0;
        @(posedge aclk);
        if (walk_live && walk_row < MAX_MAP_ROWS && walk_col < MAX_MAP_COLS &&
            !written_cells[{walk_row[6:0], walk_col[6:0]}])
            write_cell(walk_row[6:0], walk_col[6:0], 16'($urandom));
        send_request(ACT_STEP, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic unused_request();
        send_request(ACT_NONE, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Waits until every expected result has come back, then lets any trailing
    // unused request drain through the block.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input int atlas, input int map_w, input int map_h,
                              input int tile_w, input int tile_h);
        int vals [5];
        vals = '{atlas, map_w, map_h, tile_w, tile_h};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= vals[i][8:0];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        cur_map_w  = int'(map_w[7:0]);
        cur_map_h  = int'(map_h[7:0]);
        cur_tile_w = (tile_w[8:0] == 9'd0) ? 1 : int'(tile_w[8:0]);
        cur_tile_h = (tile_h[8:0] == 9'd0) ? 1 : int'(tile_h[8:0]);
    endtask

    // A render area mostly aimed at the map with a modest size, sometimes fully random.
    task automatic random_area();
        int span_x, span_y, ax, ay, aw, ah;
        span_x = cur_map_w * cur_tile_w;
        span_y = cur_map_h * cur_tile_h;
        ax = $urandom_range(0, span_x + 2 * cur_tile_w) - 2 * cur_tile_w;
        ay = $urandom_range(0, span_y + 2 * cur_tile_h) - 2 * cur_tile_h;
        aw = $urandom_range(0, 3 * cur_tile_w);
        ah = $urandom_range(0, 3 * cur_tile_h);
        if ($urandom_range(0, 7) == 0) begin
            ax = $urandom;
            aw = $urandom;
        end
        if ($urandom_range(0, 7) == 0) begin
            ay = $urandom;
            ah = $urandom;
        end
        set_area(ax[15:0], ay[15:0], aw[15:0], ah[15:0]);
    endtask

    // Random traffic. Most of it is a render area followed by a run of steps;
    // the rest is stray writes, lone steps and unused actions.
    task automatic random_traffic(input int count);
        int sent, pick, walk_len;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                if ($urandom_range(0, 1) == 0)
                    write_cell(7'($urandom), 7'($urandom), 16'($urandom));
                else
                    write_cell(7'($urandom_range(0, 7)), 7'($urandom_range(0, 7)),
                               16'($urandom));
                sent++;
            end else if (pick == 2) begin
                unused_request();
                sent++;
            end else if (pick == 3) begin
                step_walk();
                sent++;
            end else begin
                random_area();
                walk_len = $urandom_range(1, 10);
                for (int i = 0; i < walk_len; i++) step_walk();
                sent += walk_len + 1;
            end
        end
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_action     <= ACT_WRITE;
        s_cell_row   <= '0;
        s_cell_col   <= '0;
        s_tile_value <= '0;
        s_area_x     <= '0;
        s_area_y     <= '0;
        s_area_w     <= '0;
        s_area_h     <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_ATLAS_COLUMNS;
        cfg_data     <= '0;
        sender_calm  = 1'b0;
        hold_request = 1'b0;
        cur_map_w    = 0;
        cur_map_h    = 0;
        cur_tile_w   = 16;
        cur_tile_h   = 16;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: the map is empty, so every walk is empty too.
        step_walk();
        unused_request();
        set_area(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        step_walk();
        write_cell(7'd0, 7'd0, 16'sh8000);
        write_cell(7'd127, 7'd127, 16'sh7FFF);
        write_cell(7'd0, 7'd127, 16'sh0000);
        write_cell(7'd127, 7'd0, 16'shFFFF);
        drain();

        // Small map: walk the whole map from a huge area, then past its end.
        write_regs(3, 4, 3, 16, 8);
        write_cell(7'd0, 7'd1, 16'sd5);
        write_cell(7'd0, 7'd2, 16'shFFFF);
        write_cell(7'd2, 7'd3, 16'sd32767);
        set_area(16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 13; i++) step_walk();
        // A start beyond the right edge leaves nothing to walk.
        set_area(16'sh7FFF, 16'sd0, 16'd0, 16'd0);
        step_walk();
        drain();

        // Largest map and atlas, with tiles of 256 pixels. The receiver holds
        // off here while requests keep coming.
        write_regs(255, 128, 128, 256, 256);
        hold_request = 1'b1;
        random_traffic(8);
        drain();

        // Zero registers act as one; map sizes above the store are limited.
        write_regs(0, 200, 255, 0, 0);
        random_traffic(8);
        drain();

        write_regs($urandom_range(0, 255), $urandom_range(0, 16), $urandom_range(0, 16),
                   $urandom_range(0, 511), $urandom_range(0, 511));
        random_traffic(8);
        drain();

        write_regs($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 255),
                   $urandom_range(1, 40), $urandom_range(1, 40));
        random_traffic(8);
        drain();

        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
